// ===== rtl/vopg_pkg.sv =====
package vopg_pkg;

  localparam int FRAME_HEIGHT = 720;
  localparam int LINE_WIDTH   = 1280;
  localparam int SINE_DEPTH   = 256;
  localparam int FRAC_W       = 8;

  localparam int ROW_W   = 10;
  localparam int COL_W   = 11;
  localparam int FREQ_W  = 9;
  localparam int AMP_W   = 8;
  localparam int PHASE_W = 11;
  localparam int CYC_W   = 11;
  localparam int POS_W   = 12;
  localparam int CCYC_W  = 17;
  localparam int TAB_W   = 17;
  localparam int NOISE_W = 16;
  localparam int LVL_W   = 8;
  localparam int IDX_W   = $clog2(SINE_DEPTH);
  localparam int STAGES  = 14;
  localparam int NUM_CH  = 3;
  localparam int NUM_OSC = 2 * NUM_CH;
  localparam int CFG_W   = 33;
  localparam int CFG_IDX_W = 3;
  localparam logic [NOISE_W-1:0] NOISE_SEED = 16'hACE1;

  // Row oscillator arithmetic.
  localparam int RP_W    = ROW_W + CYC_W;
  localparam int RW_W    = RP_W - FRAC_W;
  localparam int RS_W    = $clog2(FRAME_HEIGHT);
  localparam int R_RECIP = (2 ** RW_W) / FRAME_HEIGHT;
  localparam int RQ_W    = RW_W - RS_W + 1;
  localparam int RM_W    = RS_W + FRAC_W;
  localparam int R_N     = FRAME_HEIGHT * (2 ** FRAC_W);
  localparam int RX_W    = $clog2(R_N * SINE_DEPTH);
  localparam int R_KI    = SINE_DEPTH * ((2 ** RX_W) / R_N);
  localparam int RKI_W   = $clog2(R_KI + 1);
  localparam int RPR_W   = FREQ_W + RS_W;
  localparam int RPX_W   = RPR_W + FRAC_W;
  localparam int R_RR    = (2 ** RPX_W) / FRAME_HEIGHT;
  localparam int RRR_W   = $clog2(R_RR + 1);

  // Column oscillator arithmetic.
  localparam int CP_W    = POS_W + CCYC_W;
  localparam int CW_W    = CP_W - FRAC_W;
  localparam int CS_W    = $clog2(LINE_WIDTH);
  localparam int C_RECIP = (2 ** CW_W) / LINE_WIDTH;
  localparam int CQ_W    = CW_W - CS_W + 1;
  localparam int CM_W    = CS_W + FRAC_W;
  localparam int C_N     = LINE_WIDTH * (2 ** FRAC_W);
  localparam int CX_W    = $clog2(C_N * SINE_DEPTH);
  localparam int C_KI    = SINE_DEPTH * ((2 ** CX_W) / C_N);
  localparam int CKI_W   = $clog2(C_KI + 1);
  localparam int CPR_W   = AMP_W + CS_W;
  localparam int C_RR    = (2 ** CPR_W) / LINE_WIDTH;
  localparam int CRR_W   = $clog2(C_RR + 1);

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_RAMP   = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_NOISE  = 2'd3
  } wave_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE      = 3'd0,
    CFG_ROW_FREQUENCY  = 3'd1,
    CFG_COLUMN_PHASE   = 3'd2,
    CFG_ROW_CYCLES     = 3'd3,
    CFG_COLUMN_WAVE    = 3'd4,
    CFG_ROW_WAVE       = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [COL_W-1:0] pixel_column;
    logic [ROW_W-1:0] pixel_row;
  } pixel_in_t;

  typedef struct packed {
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
  } pixel_out_t;

  typedef struct packed {
    logic [AMP_W-1:0]   amp;
    logic [FREQ_W-1:0]  freq;
    logic [PHASE_W-1:0] phase;
    logic [CYC_W-1:0]   rcyc;
    wave_t              row_wave;
    wave_t              col_wave;
  } chan_cfg_t;

  typedef logic [TAB_W-1:0] sine_tab_t [SINE_DEPTH];

  function automatic logic [NOISE_W-1:0] lfsr_step(input logic [NOISE_W-1:0] r);
    logic fb;
    fb = r[0] ^ r[2] ^ r[3] ^ r[5];
    return {fb, r[NOISE_W-1:1]};
  endfunction

  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    u2 = (u * u) >> 16;
    t  = 64'd11;
    t  = 64'd307 - ((u2 * t) >> 16);
    t  = 64'd5223 - ((u2 * t) >> 16);
    t  = 64'd42334 - ((u2 * t) >> 16);
    t  = 64'd102944 - ((u2 * t) >> 16);
    s  = (u * t) >> 16;
    if (s > 64'd65536) begin
      s = 64'd65536;
    end
    return s;
  endfunction

  function automatic sine_tab_t sine_init();
    sine_tab_t   tab;
    logic [63:0] f;
    logic [63:0] u;
    logic [63:0] s;
    logic [1:0]  q;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      f = (64'(k) * 64'd65536) / SINE_DEPTH;
      q = f[15:14];
      u = {48'd0, f[13:0], 2'b00};
      if (q[0]) begin
        u = 64'd65536 - u;
      end
      s = quarter_sine(u);
      if (!q[1]) begin
        tab[k] = TAB_W'((64'd65536 + s) >> 1);
      end else begin
        tab[k] = TAB_W'((64'd65536 - s) >> 1);
      end
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = sine_init();

endpackage

// ===== rtl/vopg_chan.sv =====
module vopg_chan (
  input  logic                          clk,
  input  logic [vopg_pkg::STAGES-1:0]   en,
  input  vopg_pkg::chan_cfg_t           cfg,
  input  logic [vopg_pkg::COL_W-1:0]    in_col,
  input  logic [vopg_pkg::ROW_W-1:0]    in_row,
  input  logic [vopg_pkg::NOISE_W-1:0]  row_noise,
  input  logic [vopg_pkg::NOISE_W-1:0]  col_noise,
  output logic [vopg_pkg::LVL_W-1:0]    level
);

  localparam int FRAC_W = vopg_pkg::FRAC_W;
  localparam int RW_W   = vopg_pkg::RW_W;
  localparam int RS_W   = vopg_pkg::RS_W;
  localparam int RQ_W   = vopg_pkg::RQ_W;
  localparam int RM_W   = vopg_pkg::RM_W;
  localparam int RX_W   = vopg_pkg::RX_W;
  localparam int RPR_W  = vopg_pkg::RPR_W;
  localparam int RPX_W  = vopg_pkg::RPX_W;
  localparam int CW_W   = vopg_pkg::CW_W;
  localparam int CS_W   = vopg_pkg::CS_W;
  localparam int CQ_W   = vopg_pkg::CQ_W;
  localparam int CM_W   = vopg_pkg::CM_W;
  localparam int CX_W   = vopg_pkg::CX_W;
  localparam int CPR_W  = vopg_pkg::CPR_W;
  localparam int IDX_W  = vopg_pkg::IDX_W;
  localparam int CCYC_W = vopg_pkg::CCYC_W;
  localparam int TAB_W  = vopg_pkg::TAB_W;
  localparam int LVL_W  = vopg_pkg::LVL_W;
  localparam int POS_W  = vopg_pkg::POS_W;

  // Sideband carried alongside the oscillator stages.
  logic [POS_W-1:0]  pos_r [7];
  logic [CCYC_W-1:0] rnz_r [6];
  logic [LVL_W-1:0]  cnz_r [13];

  logic [POS_W-1:0]  pos_nxt;
  logic [CCYC_W-1:0] rnz_nxt;
  logic [LVL_W-1:0]  cnz_nxt;
  logic [vopg_pkg::NOISE_W+vopg_pkg::FREQ_W-1:0] rnz_p;
  logic [vopg_pkg::NOISE_W+vopg_pkg::AMP_W-1:0]  cnz_p;

  assign pos_nxt = POS_W'(in_col) + POS_W'(cfg.phase);
  assign rnz_p   = row_noise * cfg.freq;
  assign cnz_p   = col_noise * cfg.amp;
  assign rnz_nxt = rnz_p[FRAC_W +: CCYC_W];
  assign cnz_nxt = cnz_p[16 +: LVL_W];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos_r[0] <= pos_nxt;
      rnz_r[0] <= rnz_nxt;
      cnz_r[0] <= cnz_nxt;
    end
    for (int k = 1; k < 7; k++) begin
      if (en[k]) begin
        pos_r[k] <= pos_r[k-1];
      end
    end
    for (int k = 1; k < 6; k++) begin
      if (en[k]) begin
        rnz_r[k] <= rnz_r[k-1];
      end
    end
    for (int k = 1; k < 13; k++) begin
      if (en[k]) begin
        cnz_r[k] <= cnz_r[k-1];
      end
    end
  end

  // ---------------- Row oscillator, stages 1 to 7 ----------------
  logic [vopg_pkg::RP_W-1:0] rp_r, rp_nxt;
  logic [RW_W-1:0]           rw_r;
  logic [FRAC_W-1:0]         rlo2_r, rlo3_r;
  logic [RQ_W-1:0]           rq_r, rq_nxt;
  logic [2*RW_W-1:0]         rq_p;
  logic [RW_W-1:0]           rrem;
  logic [RS_W-1:0]           rwrap_r, rwrap_nxt;
  logic [RM_W-1:0]           rm;
  logic [RM_W-1:0]           rm4_r;
  logic [RM_W+vopg_pkg::RKI_W-1:0] rki_p;
  logic [IDX_W-1:0]          rqi_r, rqi_nxt;
  logic [RPR_W-1:0]          rpr4_r, rpr5_r, rpr_nxt;
  logic                      rsq4_r, rsq5_r, rsq6_r, rsq_nxt;
  logic [RX_W-1:0]           rix_rem;
  logic [IDX_W-1:0]          ridx_r, ridx_nxt;
  logic [RPX_W-1:0]          rpx4, rpx5;
  logic [RPX_W+vopg_pkg::RRR_W-1:0] rrq_p;
  logic [CCYC_W-1:0]         rrq_r, rrq_nxt;
  logic [TAB_W-1:0]          rtab_r;
  logic [RPX_W-1:0]          rramp_rem;
  logic [CCYC_W-1:0]         rramp_r, rramp_nxt;
  logic [vopg_pkg::FREQ_W+TAB_W-1:0] rsin_p;
  logic [CCYC_W-1:0]         ccyc_r, ccyc_nxt;

  assign rp_nxt = in_row * cfg.rcyc;

  assign rq_p   = rp_r[vopg_pkg::RP_W-1:FRAC_W] * (2*RW_W)'(vopg_pkg::R_RECIP);
  assign rq_nxt = rq_p[RW_W +: RQ_W];

  // The reciprocal estimate is low by at most one, so one subtract corrects it.
  assign rrem      = rw_r - RW_W'(rq_r * RW_W'(vopg_pkg::FRAME_HEIGHT));
  assign rwrap_nxt = (rrem >= RW_W'(vopg_pkg::FRAME_HEIGHT))
                     ? RS_W'(rrem - RW_W'(vopg_pkg::FRAME_HEIGHT)) : RS_W'(rrem);

  assign rm      = {rwrap_r, rlo3_r};
  assign rki_p   = rm * (RM_W+vopg_pkg::RKI_W)'(vopg_pkg::R_KI);
  assign rqi_nxt = rki_p[RX_W +: IDX_W];
  assign rpr_nxt = cfg.freq * rwrap_r;
  assign rsq_nxt = ({1'b0, rwrap_r, 1'b0} >= (RS_W+2)'(vopg_pkg::FRAME_HEIGHT));

  assign rix_rem  = RX_W'(rm4_r) * RX_W'(vopg_pkg::SINE_DEPTH)
                    - RX_W'(rqi_r * RX_W'(vopg_pkg::R_N));
  assign ridx_nxt = (rix_rem >= RX_W'(vopg_pkg::R_N)) ? rqi_r + 1'b1 : rqi_r;
  assign rpx4     = {rpr4_r, {FRAC_W{1'b0}}};
  assign rrq_p    = rpx4 * (RPX_W+vopg_pkg::RRR_W)'(vopg_pkg::R_RR);
  assign rrq_nxt  = rrq_p[RPX_W +: CCYC_W];

  assign rpx5      = {rpr5_r, {FRAC_W{1'b0}}};
  assign rramp_rem = rpx5 - RPX_W'(rrq_r * RPX_W'(vopg_pkg::FRAME_HEIGHT));
  assign rramp_nxt = (rramp_rem >= RPX_W'(vopg_pkg::FRAME_HEIGHT)) ? rrq_r + 1'b1 : rrq_r;

  assign rsin_p = cfg.freq * rtab_r;

  always_comb begin
    case (cfg.row_wave)
      vopg_pkg::WAVE_SINE:   ccyc_nxt = rsin_p[FRAC_W +: CCYC_W];
      vopg_pkg::WAVE_RAMP:   ccyc_nxt = rramp_r;
      vopg_pkg::WAVE_SQUARE: ccyc_nxt = rsq6_r ? {cfg.freq, {FRAC_W{1'b0}}} : '0;
      vopg_pkg::WAVE_NOISE:  ccyc_nxt = rnz_r[5];
      default:               ccyc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rp_r <= rp_nxt;
    end
    if (en[1]) begin
      rw_r   <= rp_r[vopg_pkg::RP_W-1:FRAC_W];
      rlo2_r <= rp_r[FRAC_W-1:0];
      rq_r   <= rq_nxt;
    end
    if (en[2]) begin
      rwrap_r <= rwrap_nxt;
      rlo3_r  <= rlo2_r;
    end
    if (en[3]) begin
      rm4_r  <= rm;
      rqi_r  <= rqi_nxt;
      rpr4_r <= rpr_nxt;
      rsq4_r <= rsq_nxt;
    end
    if (en[4]) begin
      ridx_r <= ridx_nxt;
      rrq_r  <= rrq_nxt;
      rpr5_r <= rpr4_r;
      rsq5_r <= rsq4_r;
    end
    if (en[5]) begin
      rtab_r  <= vopg_pkg::SINE_TABLE[ridx_r];
      rramp_r <= rramp_nxt;
      rsq6_r  <= rsq5_r;
    end
    if (en[6]) begin
      ccyc_r <= ccyc_nxt;
    end
  end

  // ---------------- Column oscillator, stages 8 to 14 ----------------
  logic [vopg_pkg::CP_W-1:0] cp_r, cp_nxt;
  logic [CW_W-1:0]           cw_r;
  logic [FRAC_W-1:0]         clo9_r, clo10_r;
  logic [CQ_W-1:0]           cq_r, cq_nxt;
  logic [2*CW_W-1:0]         cq_p;
  logic [CW_W-1:0]           crem;
  logic [CS_W-1:0]           cwrap_r, cwrap_nxt;
  logic [CM_W-1:0]           cm;
  logic [CM_W-1:0]           cm11_r;
  logic [CM_W+vopg_pkg::CKI_W-1:0] cki_p;
  logic [IDX_W-1:0]          cqi_r, cqi_nxt;
  logic [CPR_W-1:0]          cpr11_r, cpr12_r, cpr_nxt;
  logic                      csq11_r, csq12_r, csq13_r, csq_nxt;
  logic [CX_W-1:0]           cix_rem;
  logic [IDX_W-1:0]          cidx_r, cidx_nxt;
  logic [CPR_W+vopg_pkg::CRR_W-1:0] crq_p;
  logic [LVL_W-1:0]          crq_r, crq_nxt;
  logic [TAB_W-1:0]          ctab_r;
  logic [CPR_W-1:0]          cramp_rem;
  logic [LVL_W-1:0]          cramp_r, cramp_nxt;
  logic [vopg_pkg::AMP_W+TAB_W-1:0] csin_p;
  logic [LVL_W-1:0]          lvl_r, lvl_nxt;

  assign cp_nxt = pos_r[6] * ccyc_r;

  assign cq_p   = cp_r[vopg_pkg::CP_W-1:FRAC_W] * (2*CW_W)'(vopg_pkg::C_RECIP);
  assign cq_nxt = cq_p[CW_W +: CQ_W];

  assign crem      = cw_r - CW_W'(cq_r * CW_W'(vopg_pkg::LINE_WIDTH));
  assign cwrap_nxt = (crem >= CW_W'(vopg_pkg::LINE_WIDTH))
                     ? CS_W'(crem - CW_W'(vopg_pkg::LINE_WIDTH)) : CS_W'(crem);

  assign cm      = {cwrap_r, clo10_r};
  assign cki_p   = cm * (CM_W+vopg_pkg::CKI_W)'(vopg_pkg::C_KI);
  assign cqi_nxt = cki_p[CX_W +: IDX_W];
  assign cpr_nxt = cfg.amp * cwrap_r;
  assign csq_nxt = ({1'b0, cwrap_r, 1'b0} >= (CS_W+2)'(vopg_pkg::LINE_WIDTH));

  assign cix_rem  = CX_W'(cm11_r) * CX_W'(vopg_pkg::SINE_DEPTH)
                    - CX_W'(cqi_r * CX_W'(vopg_pkg::C_N));
  assign cidx_nxt = (cix_rem >= CX_W'(vopg_pkg::C_N)) ? cqi_r + 1'b1 : cqi_r;
  assign crq_p    = cpr11_r * (CPR_W+vopg_pkg::CRR_W)'(vopg_pkg::C_RR);
  assign crq_nxt  = crq_p[CPR_W +: LVL_W];

  assign cramp_rem = cpr12_r - CPR_W'(crq_r * CPR_W'(vopg_pkg::LINE_WIDTH));
  assign cramp_nxt = (cramp_rem >= CPR_W'(vopg_pkg::LINE_WIDTH)) ? crq_r + 1'b1 : crq_r;

  assign csin_p = cfg.amp * ctab_r;

  always_comb begin
    case (cfg.col_wave)
      vopg_pkg::WAVE_SINE:   lvl_nxt = csin_p[16 +: LVL_W];
      vopg_pkg::WAVE_RAMP:   lvl_nxt = cramp_r;
      vopg_pkg::WAVE_SQUARE: lvl_nxt = csq13_r ? cfg.amp : '0;
      vopg_pkg::WAVE_NOISE:  lvl_nxt = cnz_r[12];
      default:               lvl_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      cp_r <= cp_nxt;
    end
    if (en[8]) begin
      cw_r   <= cp_r[vopg_pkg::CP_W-1:FRAC_W];
      clo9_r <= cp_r[FRAC_W-1:0];
      cq_r   <= cq_nxt;
    end
    if (en[9]) begin
      cwrap_r <= cwrap_nxt;
      clo10_r <= clo9_r;
    end
    if (en[10]) begin
      cm11_r  <= cm;
      cqi_r   <= cqi_nxt;
      cpr11_r <= cpr_nxt;
      csq11_r <= csq_nxt;
    end
    if (en[11]) begin
      cidx_r  <= cidx_nxt;
      crq_r   <= crq_nxt;
      cpr12_r <= cpr11_r;
      csq12_r <= csq11_r;
    end
    if (en[12]) begin
      ctab_r  <= vopg_pkg::SINE_TABLE[cidx_r];
      cramp_r <= cramp_nxt;
      csq13_r <= csq12_r;
    end
    if (en[13]) begin
      lvl_r <= lvl_nxt;
    end
  end

  assign level = lvl_r;

endmodule

// ===== rtl/video_oscillator_pattern_generator_unit.sv =====
// Throughput: one pixel per cycle unless out_ready stalls the output; each channel is
// a 14-stage pipeline whose stages hold under back-pressure one by one, so bubbles
// are squeezed out.
// Reset (synchronous, rst_n low): all configuration registers clear to zero,
// the noise register loads 0xACE1 and every pipeline stage is emptied.
module video_oscillator_pattern_generator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vopg_pkg::pixel_in_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vopg_pkg::pixel_out_t               out_data,
  input  logic                               cfg_we,
  input  logic [vopg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vopg_pkg::CFG_W-1:0]         cfg_data
);

  localparam int NUM_CH  = vopg_pkg::NUM_CH;
  localparam int NUM_OSC = vopg_pkg::NUM_OSC;
  localparam int STAGES  = vopg_pkg::STAGES;
  localparam int NOISE_W = vopg_pkg::NOISE_W;

  logic [NUM_CH*vopg_pkg::AMP_W-1:0]   amp_r;
  logic [NUM_CH*vopg_pkg::FREQ_W-1:0]  freq_r;
  logic [NUM_CH*vopg_pkg::PHASE_W-1:0] phase_r;
  logic [NUM_CH*vopg_pkg::CYC_W-1:0]   rcyc_r;
  logic [2*NUM_CH-1:0]                 cwave_r;
  logic [2*NUM_CH-1:0]                 rwave_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r   <= '0;
      freq_r  <= '0;
      phase_r <= '0;
      rcyc_r  <= '0;
      cwave_r <= '0;
      rwave_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vopg_pkg::CFG_AMPLITUDE:     amp_r   <= cfg_data[$bits(amp_r)-1:0];
        vopg_pkg::CFG_ROW_FREQUENCY: freq_r  <= cfg_data[$bits(freq_r)-1:0];
        vopg_pkg::CFG_COLUMN_PHASE:  phase_r <= cfg_data[$bits(phase_r)-1:0];
        vopg_pkg::CFG_ROW_CYCLES:    rcyc_r  <= cfg_data[$bits(rcyc_r)-1:0];
        vopg_pkg::CFG_COLUMN_WAVE:   cwave_r <= cfg_data[$bits(cwave_r)-1:0];
        vopg_pkg::CFG_ROW_WAVE:      rwave_r <= cfg_data[$bits(rwave_r)-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or the stage after it moves.
  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] en;
  logic              in_fire;

  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign in_fire   = in_valid && in_ready;
  assign out_valid = v_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Noise draws. The register steps once per noise oscillator in the order
  // red row, red column, green row, green column, blue row, blue column, so
  // each oscillator takes the value after its own rank among them.
  logic [NOISE_W-1:0] lfsr_r, lfsr_nxt;
  logic [NOISE_W-1:0] steps [NUM_OSC+1];
  logic [NOISE_W-1:0] draw [NUM_OSC];
  logic [2:0]         rank;
  logic               is_noise;

  always_comb begin
    steps[0] = lfsr_r;
    for (int k = 1; k <= NUM_OSC; k++) begin
      steps[k] = vopg_pkg::lfsr_step(steps[k-1]);
    end
    rank = '0;
    for (int j = 0; j < NUM_OSC; j++) begin
      if (j % 2 == 0) begin
        is_noise = (rwave_r[j +: 2] == vopg_pkg::WAVE_NOISE);
      end else begin
        is_noise = (cwave_r[(j-1) +: 2] == vopg_pkg::WAVE_NOISE);
      end
      draw[j] = steps[rank + 3'd1];
      if (is_noise) begin
        rank = rank + 3'd1;
      end
    end
    lfsr_nxt = steps[rank];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= vopg_pkg::NOISE_SEED;
    end else if (in_fire) begin
      lfsr_r <= lfsr_nxt;
    end
  end

  logic [vopg_pkg::LVL_W-1:0] lvl [NUM_CH];

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chan
    vopg_pkg::chan_cfg_t ccfg;

    assign ccfg.amp      = amp_r[ch*vopg_pkg::AMP_W +: vopg_pkg::AMP_W];
    assign ccfg.freq     = freq_r[ch*vopg_pkg::FREQ_W +: vopg_pkg::FREQ_W];
    assign ccfg.phase    = phase_r[ch*vopg_pkg::PHASE_W +: vopg_pkg::PHASE_W];
    assign ccfg.rcyc     = rcyc_r[ch*vopg_pkg::CYC_W +: vopg_pkg::CYC_W];
    assign ccfg.row_wave = vopg_pkg::wave_t'(rwave_r[2*ch +: 2]);
    assign ccfg.col_wave = vopg_pkg::wave_t'(cwave_r[2*ch +: 2]);

    vopg_chan u_chan (
      .clk       (clk),
      .en        (en),
      .cfg       (ccfg),
      .in_col    (in_data.pixel_column),
      .in_row    (in_data.pixel_row),
      .row_noise (draw[2*ch]),
      .col_noise (draw[2*ch+1]),
      .level     (lvl[ch])
    );
  end

  assign out_data.red_level   = lvl[0];
  assign out_data.green_level = lvl[1];
  assign out_data.blue_level  = lvl[2];

endmodule

// ===== verif/video_oscillator_pattern_generator_unit_checker.sv =====
module video_oscillator_pattern_generator_unit_checker
  import vopg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  pixel_in_t              in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  pixel_out_t             out_data,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     pending,
  output int                     errors
);

  logic [23:0]        amp_regs;
  logic [26:0]        freq_regs;
  logic [32:0]        phase_regs;
  logic [32:0]        rcyc_regs;
  logic [5:0]         col_wave_regs;
  logic [5:0]         row_wave_regs;
  logic [NOISE_W-1:0] noise_state;
  logic [63:0]        wave_table [SINE_DEPTH];
  pixel_out_t         level_queue [$];

  function automatic logic [63:0] quarter_wave(input logic [63:0] u);
    logic [63:0] sq;
    logic [63:0] acc;
    sq  = (u * u) >> 16;
    acc = 64'd307 - ((sq * 64'd11) >> 16);
    acc = 64'd5223 - ((sq * acc) >> 16);
    acc = 64'd42334 - ((sq * acc) >> 16);
    acc = 64'd102944 - ((sq * acc) >> 16);
    acc = (u * acc) >> 16;
    return (acc > 64'd65536) ? 64'd65536 : acc;
  endfunction

  initial begin
    logic [63:0] f;
    logic [63:0] u;
    logic [63:0] s;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      f = (64'(k) * 64'd65536) / SINE_DEPTH;
      u = (f & 64'h3FFF) << 2;
      if (f[14]) begin
        u = 64'd65536 - u;
      end
      s = quarter_wave(u);
      wave_table[k] = f[15] ? (64'd65536 - s) >> 1 : (64'd65536 + s) >> 1;
    end
  end

  // Advances the noise register; blocking so several draws chain within a beat.
  function automatic logic [63:0] next_noise();
    logic fb;
    fb = noise_state[0] ^ noise_state[2] ^ noise_state[3] ^ noise_state[5];
    noise_state = {fb, noise_state[NOISE_W-1:1]};
    return 64'(noise_state);
  endfunction

  function automatic logic [63:0] osc_level(input logic [63:0] scale, input logic [63:0] cyc,
                                            input logic [63:0] pos, input logic [63:0] span,
                                            input wave_t form);
    logic [63:0] prod;
    logic [63:0] wrapped;
    logic [63:0] idx;
    prod    = pos * cyc;
    wrapped = (prod >> 8) % span;
    case (form)
      WAVE_SINE: begin
        idx = ((prod % (span * 256)) * SINE_DEPTH) / (span * 256);
        return (scale * wave_table[idx]) >> 16;
      end
      WAVE_RAMP:   return (scale * wrapped) / span;
      WAVE_SQUARE: return (2 * wrapped < span) ? 64'd0 : scale;
      default:     return (next_noise() * scale) >> 16;
    endcase
  endfunction

  function automatic pixel_out_t predict_levels(input pixel_in_t px);
    logic [7:0]  lv [3];
    logic [63:0] ccyc;
    pixel_out_t  res;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      ccyc = osc_level(64'(freq_regs[9*ch +: 9]) << 8, 64'(rcyc_regs[11*ch +: 11]),
                       64'(px.pixel_row), FRAME_HEIGHT, wave_t'(row_wave_regs[2*ch +: 2]));
      ccyc = ccyc & 64'h1FFFF;
      lv[ch] = 8'(osc_level(64'(amp_regs[8*ch +: 8]), ccyc,
                            64'(px.pixel_column) + 64'(phase_regs[11*ch +: 11]),
                            LINE_WIDTH, wave_t'(col_wave_regs[2*ch +: 2])));
    end
    res.red_level   = lv[0];
    res.green_level = lv[1];
    res.blue_level  = lv[2];
    return res;
  endfunction

  assign pending = level_queue.size();

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst_n) begin
      amp_regs      <= '0;
      freq_regs     <= '0;
      phase_regs    <= '0;
      rcyc_regs     <= '0;
      col_wave_regs <= '0;
      row_wave_regs <= '0;
      noise_state   = NOISE_SEED;
      level_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AMPLITUDE:     amp_regs      <= cfg_data[23:0];
          CFG_ROW_FREQUENCY: freq_regs     <= cfg_data[26:0];
          CFG_COLUMN_PHASE:  phase_regs    <= cfg_data[32:0];
          CFG_ROW_CYCLES:    rcyc_regs     <= cfg_data[32:0];
          CFG_COLUMN_WAVE:   col_wave_regs <= cfg_data[5:0];
          CFG_ROW_WAVE:      row_wave_regs <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        level_queue.push_back(predict_levels(in_data));
      end
      if (out_valid && out_ready) begin
        if (level_queue.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result beat %h", out_data);
          end
        end else begin
          want = level_queue.pop_front();
          if (want !== out_data) begin
            errors++;
            if (errors <= 10) begin
              $display("level mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red_level, want.green_level, want.blue_level,
                       out_data.red_level, out_data.green_level, out_data.blue_level);
            end
          end
        end
      end
    end
  end

  initial errors = 0;

endmodule

// ===== verif/video_oscillator_pattern_generator_unit_tb.sv =====
module video_oscillator_pattern_generator_unit_tb;
  import vopg_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  pixel_in_t            in_data;
  logic                 out_valid;
  logic                 out_ready;
  pixel_out_t           out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   pending;
  int                   errors;
  int                   cycle_count;
  bit                   hold_request;
  bit                   drain_fast;

  video_oscillator_pattern_generator_unit uut (.*);

  video_oscillator_pattern_generator_unit_checker checker_i (.*);

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("video_oscillator_pattern_generator_unit verification failed");
      $finish;
    end
  end

  // Receiver: random stall per beat, with an occasional long hold-off.
  initial begin
    int wait_cycles;
    out_ready = 1'b0;
    forever begin
      wait_cycles = drain_fast ? 0 : $urandom_range(0, 7);
      if (hold_request) begin
        wait_cycles  = 300;
        hold_request = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(input logic [10:0] col, input logic [9:0] row, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_data.pixel_column  <= col;
    in_data.pixel_row     <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_setting(input logic [CFG_W-1:0] amp, input logic [CFG_W-1:0] freq,
                              input logic [CFG_W-1:0] phase, input logic [CFG_W-1:0] rcyc,
                              input logic [CFG_W-1:0] cwave, input logic [CFG_W-1:0] rwave);
    wait_idle();
    write_reg(CFG_AMPLITUDE, amp);
    write_reg(CFG_ROW_FREQUENCY, freq);
    write_reg(CFG_COLUMN_PHASE, phase);
    write_reg(CFG_ROW_CYCLES, rcyc);
    write_reg(CFG_COLUMN_WAVE, cwave);
    write_reg(CFG_ROW_WAVE, rwave);
    // Indexes past the register list must be ignored.
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'($urandom_range(6, 7));
    cfg_data  <= CFG_W'({$urandom, $urandom});
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] rand_cfg();
    return CFG_W'({$urandom, $urandom});
  endfunction

  task automatic send_random(input int count, input bit gapless);
    logic [10:0] col;
    logic [9:0]  row;
    for (int i = 0; i < count; i++) begin
      col = 11'($urandom);
      row = 10'($urandom);
      case ($urandom_range(0, 3))
        0: col = 11'($urandom_range(1270, 1290));
        1: row = 10'($urandom_range(710, 730));
        default: ;
      endcase
      send_pixel(col, row, gapless ? 0 : $urandom_range(0, 7));
    end
  endtask

  task automatic send_directed();
    send_pixel(11'd0, 10'd0, 0);
    send_pixel(11'd2047, 10'd1023, 0);
    send_pixel(11'd1279, 10'd719, 1);
    send_pixel(11'd1280, 10'd720, 0);
    send_pixel(11'd1281, 10'd721, 2);
    send_pixel(11'd2047, 10'd0, 0);
    send_pixel(11'd0, 10'd1023, 0);
    send_pixel(11'd640, 10'd360, 3);
    send_pixel(11'd1365, 10'd682, 0);
    send_pixel(11'd682, 10'd341, 0);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cycle_count  = 0;
    hold_request = 1'b0;
    drain_fast   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset: all waves sine, zero scales.
    send_directed();

    // Every register at its maximum, all noise.
    load_setting('1, '1, '1, '1, '1, '1);
    send_directed();
    send_random(60, 0);

    // Pure waveforms per setting, maximum amplitude and mixed row frequencies.
    for (int w = 0; w < 4; w++) begin
      load_setting(CFG_W'(24'hFFFFFF), CFG_W'({9'd300, 9'd511, 9'd1}), rand_cfg(), rand_cfg(),
                   CFG_W'({3{2'(w)}}), CFG_W'({3{2'(3 - w)}}));
      send_directed();
      send_random(120, 0);
    end

    // Long receiver hold-off while the sender keeps pushing, then gapless traffic.
    load_setting(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
    hold_request = 1'b1;
    send_random(100, 1);
    wait_idle();
    drain_fast = 1'b1;
    send_random(150, 1);
    drain_fast = 1'b0;

    // Mixed random settings.
    for (int p = 0; p < 8; p++) begin
      load_setting(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
      send_random(60, 0);
      wait_idle();
      send_random(60, p[0]);
    end

    // Back to all-zero registers.
    load_setting('0, '0, '0, '0, '0, '0);
    send_random(40, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("video_oscillator_pattern_generator_unit verification clean");
    end else begin
      $display("video_oscillator_pattern_generator_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vopg_pkg.sv
rtl/vopg_chan.sv
rtl/video_oscillator_pattern_generator_unit.sv
verif/video_oscillator_pattern_generator_unit_checker.sv
verif/video_oscillator_pattern_generator_unit_tb.sv
